// ===== src/cssve_pkg.sv =====
package cssve_pkg;

    // Fraction bits of the unit vector components.
    localparam int UNIT_FRAC_BITS = 14;

    localparam int CSS_COUNT = 6;
    localparam int AXES      = 3;

    localparam int VW        = 16;            // voltage width, Q4.12
    localparam int PW        = 16;            // percent-on width
    localparam int AXW       = 16;            // axis component width, Q1.14
    localparam int GW        = 64;            // geometry register width
    localparam int SCALE_SH  = 12;            // Q4.12 product back to Q4.12
    localparam int OW        = 16;            // output component width
    localparam int CIW       = $clog2(CSS_COUNT);

    localparam int PRODW     = PW + 1 + AXW;  // signed percent-on times axis
    localparam int SUMW      = PRODW + 3;     // sum of six products
    localparam int MAGW      = SUMW - 1;      // magnitude of a sum
    localparam int MSBW      = $clog2(MAGW);
    localparam int NORM_LO   = 29;            // normalized maximum sits in [2^29, 2^30)
    localparam int TW        = NORM_LO + 1;
    localparam int SHW       = $clog2(NORM_LO + 1);
    localparam int SQW       = 2 * TW + 2;    // sum of three squares
    localparam int RW        = TW + 1;        // square root width
    localparam int QW        = UNIT_FRAC_BITS + 2;
    localparam int NW        = TW + UNIT_FRAC_BITS + 1;
    localparam int DW        = RW + QW;

    localparam int OUT_POS_MAX = 32767;
    localparam int OUT_NEG_MAX = 32768;

    typedef logic [CSS_COUNT-1:0][PW-1:0]   t_pct_vec;
    typedef logic [CSS_COUNT-1:0][VW-1:0]   t_volt_vec;
    typedef logic [AXES-1:0][SUMW-1:0]      t_sum_vec;
    typedef logic [AXES-1:0][TW-1:0]        t_tvec;
    typedef logic [AXES-1:0][QW-1:0]        t_qvec;

    // Per-item data that rides alongside the arithmetic.
    typedef struct packed {
        t_pct_vec        pct;
        logic [AXES-1:0] neg;
        logic            nz;
    } t_side;

endpackage

// ===== src/cssve_weight.sv =====
module cssve_weight (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  cssve_pkg::t_volt_vec                  i_volt,
    input  logic [cssve_pkg::CSS_COUNT-1:0][cssve_pkg::GW-1:0] i_geom,
    output logic                                  o_valid,
    output cssve_pkg::t_pct_vec                   o_pct,
    output cssve_pkg::t_sum_vec                   o_sum
);
    import cssve_pkg::*;

    logic [2:0]                r_vld;
    t_pct_vec                  r_pct1, r_pct2, r_pct3;
    logic signed [PRODW-1:0]   r_prod [CSS_COUNT][AXES];
    t_sum_vec                  r_sum;
    t_pct_vec                  n_pct;
    t_sum_vec                  n_sum;

    always_comb begin
        logic [2*VW-1:0]          prod;
        logic [2*VW-SCALE_SH-1:0] shr;
        for (int i = 0; i < CSS_COUNT; i++) begin
            prod = i_volt[i] * i_geom[i][PW-1:0];
            shr  = prod[2*VW-1:SCALE_SH];
            n_pct[i] = (|shr[2*VW-SCALE_SH-1:PW]) ? {PW{1'b1}} : shr[PW-1:0];
        end
    end

    always_comb begin
        logic signed [SUMW-1:0] acc;
        for (int a = 0; a < AXES; a++) begin
            acc = '0;
            for (int i = 0; i < CSS_COUNT; i++) begin
                acc = acc + SUMW'(r_prod[i][a]);
            end
            n_sum[a] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pct1 <= n_pct;
            r_pct2 <= r_pct1;
            r_pct3 <= r_pct2;
            for (int i = 0; i < CSS_COUNT; i++) begin
                for (int a = 0; a < AXES; a++) begin
                    r_prod[i][a] <= $signed({1'b0, r_pct1[i]}) *
                                    $signed(i_geom[i][AXW*(a+1) +: AXW]);
                end
            end
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_vld[2];
    assign o_pct   = r_pct3;
    assign o_sum   = r_sum;

endmodule

// ===== src/cssve_norm.sv =====
module cssve_norm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  cssve_pkg::t_pct_vec           i_pct,
    input  cssve_pkg::t_sum_vec           i_sum,
    output logic                          o_valid,
    output logic [cssve_pkg::SQW-1:0]     o_sq,
    output cssve_pkg::t_tvec              o_t,
    output cssve_pkg::t_side              o_side
);
    import cssve_pkg::*;

    logic [4:0]                       r_vld;
    t_side                            r_side4, r_side5, r_side6, r_side7, r_side8;
    logic [AXES-1:0][MAGW-1:0]        r_mag4, r_mag5;
    logic [MAGW-1:0]                  r_max4;
    logic                             r_left5;
    logic [SHW-1:0]                   r_amt5;
    t_tvec                            r_t6, r_t7, r_t8;
    logic [AXES-1:0][2*TW-1:0]        r_sq7;
    logic [SQW-1:0]                   r_sq8;

    logic [AXES-1:0][MAGW-1:0]        n_mag;
    logic [AXES-1:0]                  n_neg;
    logic [MAGW-1:0]                  n_max;
    logic [MSBW-1:0]                  n_msb;
    t_tvec                            n_t;

    // Magnitudes and sign bits of the three sums, with their maximum.
    always_comb begin
        logic [SUMW-1:0] neg_sum;
        n_max = '0;
        for (int a = 0; a < AXES; a++) begin
            n_neg[a] = i_sum[a][SUMW-1];
            neg_sum  = SUMW'(0) - i_sum[a];
            n_mag[a] = n_neg[a] ? neg_sum[MAGW-1:0] : i_sum[a][MAGW-1:0];
            if (n_mag[a] > n_max) begin
                n_max = n_mag[a];
            end
        end
    end

    always_comb begin
        n_msb = '0;
        for (int b = 0; b < MAGW; b++) begin
            if (r_max4[b]) begin
                n_msb = MSBW'(b);
            end
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_t[a] = r_left5 ? TW'(64'(r_mag5[a]) << r_amt5) : TW'(r_mag5[a] >> r_amt5);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side4.pct <= i_pct;
            r_side4.neg <= n_neg;
            r_side4.nz  <= |n_max;
            r_mag4      <= n_mag;
            r_max4      <= n_max;

            r_side5 <= r_side4;
            r_mag5  <= r_mag4;
            r_left5 <= (n_msb < MSBW'(NORM_LO));
            r_amt5  <= (n_msb < MSBW'(NORM_LO)) ? SHW'(MSBW'(NORM_LO) - n_msb)
                                                : SHW'(n_msb - MSBW'(NORM_LO));

            r_side6 <= r_side5;
            r_t6    <= n_t;

            r_side7 <= r_side6;
            r_t7    <= r_t6;
            for (int a = 0; a < AXES; a++) begin
                r_sq7[a] <= r_t6[a] * r_t6[a];
            end

            r_side8 <= r_side7;
            r_t8    <= r_t7;
            r_sq8   <= SQW'(r_sq7[0]) + SQW'(r_sq7[1]) + SQW'(r_sq7[2]);
        end
    end

    assign o_valid = r_vld[4];
    assign o_sq    = r_sq8;
    assign o_t     = r_t8;
    assign o_side  = r_side8;

endmodule

// ===== src/cssve_sqrt.sv =====
module cssve_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [cssve_pkg::SQW-1:0]     i_x,
    input  cssve_pkg::t_tvec              i_t,
    input  cssve_pkg::t_side              i_side,
    output logic                          o_valid,
    output logic [cssve_pkg::RW-1:0]      o_root,
    output cssve_pkg::t_tvec              o_t,
    output cssve_pkg::t_side              o_side
);
    import cssve_pkg::*;

    typedef struct packed {
        logic [SQW-1:0] rem;
        logic [RW-1:0]  root;
        t_tvec          t;
        t_side          side;
    } t_sq_stage;

    logic [RW-1:0] r_vld;
    t_sq_stage     r_st [RW];
    t_sq_stage     s_in;

    always_comb begin
        s_in.rem  = i_x;
        s_in.root = '0;
        s_in.t    = i_t;
        s_in.side = i_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[RW-2:0], i_valid};
        end
    end

    // One root bit per stage, most significant first. The remainder holds
    // x minus the square of the partial root.
    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int BIT = RW - 1 - k;
        t_sq_stage   prv;
        t_sq_stage   nxt;
        logic [63:0] inc;

        if (k == 0) begin : g_first
            assign prv = s_in;
        end else begin : g_next
            assign prv = r_st[k-1];
        end

        always_comb begin
            inc = (64'(prv.root) << (BIT + 1)) + (64'(1) << (2 * BIT));
            nxt = prv;
            if (64'(prv.rem) >= inc) begin
                nxt.rem  = SQW'(64'(prv.rem) - inc);
                nxt.root = prv.root | (RW'(1) << BIT);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= nxt;
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_st[RW-1].root;
    assign o_t     = r_st[RW-1].t;
    assign o_side  = r_st[RW-1].side;

endmodule

// ===== src/cssve_div.sv =====
module cssve_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [cssve_pkg::RW-1:0]      i_root,
    input  cssve_pkg::t_tvec              i_t,
    input  cssve_pkg::t_side              i_side,
    output logic                          o_valid,
    output cssve_pkg::t_qvec              o_q,
    output cssve_pkg::t_side              o_side
);
    import cssve_pkg::*;

    typedef struct packed {
        logic [AXES-1:0][DW-1:0] rem;
        logic [RW-1:0]           dvs;
        t_qvec                   q;
        t_side                   side;
    } t_div_stage;

    logic [QW:0]  r_vld;
    t_div_stage   r_st [QW+1];
    t_div_stage   n_first;

    // Numerator with half the divisor added, so that the quotient rounds.
    always_comb begin
        n_first.dvs  = (i_root == '0) ? RW'(1) : i_root;
        n_first.q    = '0;
        n_first.side = i_side;
        for (int a = 0; a < AXES; a++) begin
            n_first.rem[a] = (DW'(i_t[a]) << UNIT_FRAC_BITS) + DW'(n_first.dvs >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_first;
        end
    end

    // Restoring division, one quotient bit per stage for all three axes.
    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int BIT = QW - 1 - k;
        t_div_stage     nxt;
        logic [DW-1:0]  sub;

        always_comb begin
            nxt = r_st[k];
            sub = DW'(r_st[k].dvs) << BIT;
            for (int a = 0; a < AXES; a++) begin
                if (r_st[k].rem[a] >= sub) begin
                    nxt.rem[a]  = r_st[k].rem[a] - sub;
                    nxt.q[a]    = r_st[k].q[a] | (QW'(1) << BIT);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k+1] <= nxt;
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_q     = r_st[QW].q;
    assign o_side  = r_st[QW].side;

endmodule

// ===== src/coarse_sun_vector_estimator_core.sv =====
// Throughput: one sample per cycle while the output is not stalled; the square root (31 stages)
// and the divider (17 stages) are fully pipelined, so a new sample can enter every cycle unless o_stall is high.
// The whole pipeline advances together and holds while a result waits.
// Reset (synchronous, active low) clears all valid bits and the six
// geometry registers.
module coarse_sun_vector_estimator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [15:0]                   i_voltage_0,
    input  logic [15:0]                   i_voltage_1,
    input  logic [15:0]                   i_voltage_2,
    input  logic [15:0]                   i_voltage_3,
    input  logic [15:0]                   i_voltage_4,
    input  logic [15:0]                   i_voltage_5,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [15:0]            o_sun_x,
    output logic signed [15:0]            o_sun_y,
    output logic signed [15:0]            o_sun_z,
    output logic                          o_sun_valid,
    output logic [15:0]                   o_percent_on_0,
    output logic [15:0]                   o_percent_on_1,
    output logic [15:0]                   o_percent_on_2,
    output logic [15:0]                   o_percent_on_3,
    output logic [15:0]                   o_percent_on_4,
    output logic [15:0]                   o_percent_on_5,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cssve_pkg::CIW-1:0]     i_cfg_index,
    input  logic [cssve_pkg::GW-1:0]      i_cfg_data
);
    import cssve_pkg::*;

    logic [CSS_COUNT-1:0][GW-1:0] r_geom;
    logic                         en;
    t_volt_vec                    volt;

    logic                         w_valid;
    t_pct_vec                     w_pct;
    t_sum_vec                     w_sum;
    logic                         nm_valid;
    logic [SQW-1:0]               nm_sq;
    t_tvec                        nm_t;
    t_side                        nm_side;
    logic                         sq_valid;
    logic [RW-1:0]                sq_root;
    t_tvec                        sq_t;
    t_side                        sq_side;
    logic                         dv_valid;
    t_qvec                        dv_q;
    t_side                        dv_side;

    logic                         r_out_valid;
    logic [AXES-1:0][OW-1:0]      r_sun;
    logic                         r_sun_valid;
    t_pct_vec                     r_pct;
    logic [AXES-1:0][OW-1:0]      n_sun;

    assign en          = !r_out_valid || !i_stall;
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    assign volt = {i_voltage_5, i_voltage_4, i_voltage_3,
                   i_voltage_2, i_voltage_1, i_voltage_0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom <= '0;
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index < CIW'(CSS_COUNT))) begin
            r_geom[i_cfg_index] <= i_cfg_data;
        end
    end

    cssve_weight u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_volt  (volt),
        .i_geom  (r_geom),
        .o_valid (w_valid),
        .o_pct   (w_pct),
        .o_sum   (w_sum)
    );

    cssve_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_valid),
        .i_pct   (w_pct),
        .i_sum   (w_sum),
        .o_valid (nm_valid),
        .o_sq    (nm_sq),
        .o_t     (nm_t),
        .o_side  (nm_side)
    );

    cssve_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (nm_valid),
        .i_x     (nm_sq),
        .i_t     (nm_t),
        .i_side  (nm_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_t     (sq_t),
        .o_side  (sq_side)
    );

    cssve_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_root  (sq_root),
        .i_t     (sq_t),
        .i_side  (sq_side),
        .o_valid (dv_valid),
        .o_q     (dv_q),
        .o_side  (dv_side)
    );

    // Apply the sign and clamp to the 16-bit signed range; a zero weighted sum gives a zero vector.
    always_comb begin
        logic [63:0] q64;
        logic [63:0] qc;
        for (int a = 0; a < AXES; a++) begin
            q64 = 64'(dv_q[a]);
            qc  = q64;
            if (!dv_side.nz) begin
                n_sun[a] = '0;
            end else if (dv_side.neg[a]) begin
                qc       = (q64 > 64'(OUT_NEG_MAX)) ? 64'(OUT_NEG_MAX) : q64;
                n_sun[a] = OW'(64'(0) - qc);
            end else begin
                qc       = (q64 > 64'(OUT_POS_MAX)) ? 64'(OUT_POS_MAX) : q64;
                n_sun[a] = OW'(qc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sun       <= n_sun;
            r_sun_valid <= dv_side.nz;
            r_pct       <= dv_side.pct;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sun_x        = r_sun[0];
    assign o_sun_y        = r_sun[1];
    assign o_sun_z        = r_sun[2];
    assign o_sun_valid    = r_sun_valid;
    assign o_percent_on_0 = r_pct[0];
    assign o_percent_on_1 = r_pct[1];
    assign o_percent_on_2 = r_pct[2];
    assign o_percent_on_3 = r_pct[3];
    assign o_percent_on_4 = r_pct[4];
    assign o_percent_on_5 = r_pct[5];

    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_sun_valid) |-> (o_sun_x == 0 && o_sun_y == 0 && o_sun_z == 0))
        else $error("sun vector not zero on an invalid result");

    a_nonzero_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sun_valid) |-> !(o_sun_x == 0 && o_sun_y == 0 && o_sun_z == 0))
        else $error("valid sun vector is all zero");

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while the output is free");

endmodule

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cssve_pkg::*;

    localparam int LATENCY   = 57;
    localparam int WD_LIMIT  = 20000;
    localparam int N_RANDOM  = 1630;

    typedef struct packed {
        logic [5:0][15:0] volt;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
        logic               sv;
        logic [5:0][15:0]   pct;
    } t_sun_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [5:0][15:0] volt_drv = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [15:0] o_sun_x, o_sun_y, o_sun_z;
    logic o_sun_valid;
    logic [15:0] o_pct [6];
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CIW-1:0] i_cfg_index = '0;
    logic [GW-1:0] i_cfg_data = '0;

    always #4 i_clk = ~i_clk;

    coarse_sun_vector_estimator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_voltage_0(volt_drv[0]), .i_voltage_1(volt_drv[1]),
        .i_voltage_2(volt_drv[2]), .i_voltage_3(volt_drv[3]),
        .i_voltage_4(volt_drv[4]), .i_voltage_5(volt_drv[5]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_sun_x(o_sun_x), .o_sun_y(o_sun_y), .o_sun_z(o_sun_z),
        .o_sun_valid(o_sun_valid),
        .o_percent_on_0(o_pct[0]), .o_percent_on_1(o_pct[1]),
        .o_percent_on_2(o_pct[2]), .o_percent_on_3(o_pct[3]),
        .o_percent_on_4(o_pct[4]), .o_percent_on_5(o_pct[5]),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    logic [63:0] geometry [6];
    t_sample     pending_samples [$];
    t_sun_word   expected_words [$];
    int          errors = 0;
    int          words_seen = 0;
    int          invalid_seen = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_phase = 0;
    int          stall_mode = 0;
    bit          stim_done = 1'b0;

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_sun_word estimate_sun(t_sample s);
        t_sun_word w;
        longint sum [3];
        logic [63:0] m [3];
        logic [63:0] maxm, m2, mag, q, p, v;
        logic [2:0] neg;
        longint axis_c;
        w = '0;
        sum = '{0, 0, 0};
        for (int i = 0; i < 6; i++) begin
            p = (64'(s.volt[i]) * 64'(geometry[i][15:0])) >> 12;
            if (p > 64'hFFFF) p = 64'hFFFF;
            w.pct[i] = p[15:0];
            for (int a = 0; a < 3; a++) begin
                axis_c = longint'($signed(geometry[i][16*(a+1) +: 16]));
                sum[a] += longint'(p) * axis_c;
            end
        end
        maxm = 0;
        for (int a = 0; a < 3; a++) begin
            neg[a] = sum[a] < 0;
            m[a] = neg[a] ? 64'(-sum[a]) : 64'(sum[a]);
            if (m[a] > maxm) maxm = m[a];
        end
        if (maxm == 0) return w;
        while (maxm < (64'd1 << 29)) begin
            maxm <<= 1;
            for (int a = 0; a < 3; a++) m[a] <<= 1;
        end
        while (maxm >= (64'd1 << 30)) begin
            maxm >>= 1;
            for (int a = 0; a < 3; a++) m[a] >>= 1;
        end
        m2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        mag = isqrt(m2);
        if (mag == 0) mag = 1;
        for (int a = 0; a < 3; a++) begin
            q = ((m[a] << UNIT_FRAC_BITS) + (mag >> 1)) / mag;
            if (neg[a]) begin
                if (q > OUT_NEG_MAX) q = OUT_NEG_MAX;
                v = (64'd0 - q) & 64'hFFFF;
            end else begin
                if (q > OUT_POS_MAX) q = OUT_POS_MAX;
                v = q;
            end
            if (a == 0) w.sx = v[15:0];
            else if (a == 1) w.sy = v[15:0];
            else w.sz = v[15:0];
        end
        w.sv = 1'b1;
        return w;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_words.push_back(estimate_sun(pending_samples.pop_front()));
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    i_valid <= 1'b1;
                    volt_drv <= pending_samples[0].volt;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls follow a randomly redrawn mode: none, sparse random, periodic or dense random.
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= (stall_phase % 7) < 3;
            default: i_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_sun_word got, exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_sun_x, o_sun_y, o_sun_z, o_sun_valid,
                    {o_pct[5], o_pct[4], o_pct[3], o_pct[2], o_pct[1], o_pct[0]}};
            words_seen++;
            if (!got.sv) invalid_seen++;
            if (expected_words.size() == 0) begin
                $display("%0t unexpected word %p", $time, got);
                errors++;
            end else begin
                exp_w = expected_words.pop_front();
                if (got.sx !== exp_w.sx) begin
                    $display("%0t sun_x exp %0d got %0d", $time, exp_w.sx, got.sx);
                    errors++;
                end
                if (got.sy !== exp_w.sy) begin
                    $display("%0t sun_y exp %0d got %0d", $time, exp_w.sy, got.sy);
                    errors++;
                end
                if (got.sz !== exp_w.sz) begin
                    $display("%0t sun_z exp %0d got %0d", $time, exp_w.sz, got.sz);
                    errors++;
                end
                if (got.sv !== exp_w.sv) begin
                    $display("%0t sun_valid exp %0d got %0d", $time, exp_w.sv, got.sv);
                    errors++;
                end
                for (int i = 0; i < 6; i++) begin
                    if (got.pct[i] !== exp_w.pct[i]) begin
                        $display("%0t percent_on_%0d exp %0d got %0d", $time, i,
                                 exp_w.pct[i], got.pct[i]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_geometry(int idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx[CIW-1:0];
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx < 6) geometry[idx] = val;
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || expected_words.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_axis(int mode);
        case (mode)
            0: return 16'(16384);
            1: return 16'(-16384);
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_volt();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_geometry(int mode);
        logic [63:0] g;
        for (int i = 0; i < 6; i++) begin
            if (mode == 0) begin
                // Six faces of a cube, unity scale.
                g = '0;
                g[15:0] = 16'h1000;
                g[16*(i/2+1) +: 16] = (i % 2) ? 16'(-16384) : 16'(16384);
            end else if (mode == 1) begin
                g = {16'h8000, 16'h8000, 16'h8000, 16'hFFFF};
            end else if (mode == 2) begin
                g = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF};
            end else begin
                g = {rand_axis($urandom_range(0, 9)), rand_axis($urandom_range(0, 9)),
                     rand_axis($urandom_range(0, 9)), 16'($urandom)};
            end
            write_geometry(i, g);
        end
    endtask

    initial begin
        t_sample s;
        for (int i = 0; i < 6; i++) geometry[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero geometry after reset: every word must come back invalid.
        s.volt = {6{16'hFFFF}};
        pending_samples.push_back(s);
        drain();

        load_geometry(0);
        // An out-of-range index must leave the registers alone.
        write_geometry(6, 64'hFFFF_FFFF_FFFF_FFFF);
        write_geometry(7, 64'h1234_5678_9ABC_DEF0);
        s.volt = '0;
        pending_samples.push_back(s);
        for (int i = 0; i < 6; i++) begin
            s.volt = '0;
            s.volt[i] = 16'hFFFF;
            pending_samples.push_back(s);
        end
        s.volt = {6{16'hFFFF}};
        pending_samples.push_back(s);
        s.volt = {16'h0, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0};
        pending_samples.push_back(s);
        s.volt = {16'h0001, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF};
        pending_samples.push_back(s);
        drain();

        load_geometry(1);
        s.volt = {6{16'hFFFF}};
        pending_samples.push_back(s);
        s.volt = {6{16'h0001}};
        pending_samples.push_back(s);
        drain();
        load_geometry(2);
        s.volt = {6{16'hFFFF}};
        pending_samples.push_back(s);
        s.volt = {16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00};
        pending_samples.push_back(s);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            load_geometry(phase == 0 ? 0 : 3);
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                for (int i = 0; i < 6; i++) s.volt[i] = rand_volt();
                pending_samples.push_back(s);
            end
            drain();
        end

        stim_done = 1'b1;
        $display("Checked %0d sun vector words, %0d of them with a zero weighted sum,",
                 words_seen, invalid_seen);
        $display("across cube, extreme and random sensor geometries.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/cssve_pkg.sv
src/cssve_weight.sv
src/cssve_norm.sv
src/cssve_sqrt.sv
src/cssve_div.sv
src/coarse_sun_vector_estimator_core.sv
tb/sv/tb_top.sv
